FILE: rtl/ptt_pkg.sv
// Shared types, codes and defaults for the periodic timer table.
package ptt_pkg;

	localparam int NUM_TIMERS_DEF = 8;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_POLL   = 2'd2;

	localparam int FL_RUN    = 0;
	localparam int FL_RPT    = 1;
	localparam int FL_ADEL   = 2;
	localparam int FL_CALLED = 3;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  slot;
		logic [31:0] period;
		logic        run;
		logic        rpt;
		logic        adel;
		logic [63:0] now;
	} cmd_t;

endpackage

FILE: rtl/ptt_front.sv
// Front end: queues command beats, drops unused or out-of-range ones.
module ptt_front import ptt_pkg::*; #(
	parameter int NumTimers = NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  operation,
	input  logic [2:0]  slot,
	input  logic [31:0] interval,
	input  logic        run_now,
	input  logic        repeat_mode,
	input  logic        auto_delete,
	input  logic [63:0] now_ms,
	output logic        q_valid,
	output cmd_t        q_cmd,
	input  logic        q_pop
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       in_range;
	logic       keep;
	logic       push;

	assign in_range  = 32'(slot) < NumTimers;
	assign keep      = ((operation == OP_ADD || operation == OP_REMOVE) && in_range) ||
	                   (operation == OP_POLL);
	assign cmd_stall = cnt_q[1];
	assign push      = cmd_valid && !cmd_stall && keep;
	assign q_valid   = cnt_q != 2'd0;
	assign q_cmd     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{op: operation, slot: slot, period: interval,
			                     run: run_now, rpt: repeat_mode, adel: auto_delete,
			                     now: now_ms};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

FILE: rtl/ptt_back.sv
// Back end: slot store, add/remove execution, poll walk and result output.
module ptt_back import ptt_pkg::*; #(
	parameter int NumTimers = NUM_TIMERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       fired,
	output logic [2:0] fired_slot,
	output logic       last
);

	localparam int IW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
	localparam int CW = $clog2(NumTimers + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]           state_q;
	logic [CW-1:0]        walk_q;
	logic [63:0]          now_q;
	logic [NumTimers-1:0] valid_q;
	logic                 pend_v_q;
	logic [IW-1:0]        pend_slot_q;

	logic [31:0] per_mem [NumTimers];
	logic [63:0] exp_mem [NumTimers];
	logic [3:0]  flg_mem [NumTimers];

	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic [63:0]   e_s1;
	logic [31:0]   p_s1;
	logic [3:0]    f_s1;

	logic          v_s2;
	logic [IW-1:0] idx_s2;
	logic [63:0]   e_s2;
	logic [63:0]   np_s2;
	logic [31:0]   p_s2;
	logic [3:0]    f_s2;
	logic          once_s2;

	logic          en;
	logic          walk_done;
	logic          iss;
	logic          pop;
	logic [IW-1:0] a_idx;
	logic [63:0]   np;
	logic [63:0]   e2;
	logic          once;
	logic [63:0]   p64;
	logic          live;
	logic          expired;
	logic          catch_up;
	logic [63:0]   new_e;
	logic          hit;
	logic          emit;
	logic          drop;
	logic          wr_en;
	logic [IW-1:0] wr_idx;
	logic [63:0]   wr_e;
	logic [3:0]    wr_f;
	logic          per_we;

	assign en        = !res_valid || !res_stall;
	assign walk_done = walk_q == CW'(NumTimers);
	assign iss       = en && (state_q == ST_WALK) && !walk_done;
	assign pop       = en && (state_q == ST_IDLE) && q_valid;
	assign q_pop     = pop;
	assign a_idx     = IW'(q_cmd.slot);

	// stage 1: wrap reset and first-poll arming
	assign np   = now_q + {32'd0, p_s1};
	assign e2   = (np < e_s1 || e_s1 == 64'd0) ? np : e_s1;
	assign once = (e_s1 == 64'd0) && f_s1[FL_RUN] && !f_s1[FL_CALLED];

	// stage 2: expiry test and reschedule
	assign p64      = {32'd0, p_s2};
	assign live     = v_s2 && valid_q[idx_s2];
	assign expired  = !(e_s2 > now_q);
	assign catch_up = (now_q - e_s2) > p64;
	assign new_e    = expired ? (catch_up ? np_s2 : e_s2 + p64) : e_s2;
	assign hit      = once_s2 || expired;
	assign emit     = live && hit && (f_s2[FL_RPT] || !f_s2[FL_CALLED]);
	assign drop     = hit && !f_s2[FL_RPT] && f_s2[FL_ADEL];
	assign per_we   = pop && (q_cmd.op == OP_ADD);

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = idx_s2;
		wr_e   = new_e;
		wr_f   = hit ? (f_s2 | 4'(1 << FL_CALLED)) : f_s2;
		if (per_we) begin
			wr_en  = 1'b1;
			wr_idx = a_idx;
			wr_e   = 64'd0;
			wr_f   = {1'b0, q_cmd.adel, q_cmd.rpt, q_cmd.run};
		end else if (en && live) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			exp_mem[wr_idx] <= wr_e;
			flg_mem[wr_idx] <= wr_f;
		end
		if (per_we)
			per_mem[a_idx] <= q_cmd.period;
		if (iss) begin
			idx_s1 <= walk_q[IW-1:0];
			e_s1   <= exp_mem[walk_q[IW-1:0]];
			p_s1   <= per_mem[walk_q[IW-1:0]];
			f_s1   <= flg_mem[walk_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2  <= idx_s1;
			e_s2    <= e2;
			np_s2   <= np;
			p_s2    <= p_s1;
			f_s2    <= f_s1;
			once_s2 <= once;
			if (pop)
				now_q <= q_cmd.now;
			if (state_q == ST_WALK && emit) begin
				pend_slot_q <= idx_s2;
				fired       <= 1'b1;
				fired_slot  <= 3'(pend_slot_q);
				last        <= 1'b0;
			end
			if (state_q == ST_FIN) begin
				fired      <= pend_v_q;
				fired_slot <= pend_v_q ? 3'(pend_slot_q) : 3'd0;
				last       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			walk_q    <= '0;
			valid_q   <= '0;
			pend_v_q  <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= iss;
			v_s2      <= v_s1;
			res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (q_cmd.op)
							OP_ADD:    valid_q[a_idx] <= 1'b1;
							OP_REMOVE: valid_q[a_idx] <= 1'b0;
							OP_POLL: begin
								state_q  <= ST_WALK;
								walk_q   <= '0;
								pend_v_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (iss)
						walk_q <= walk_q + CW'(1);
					if (live && drop)
						valid_q[idx_s2] <= 1'b0;
					if (emit) begin
						pend_v_q <= 1'b1;
						if (pend_v_q)
							res_valid <= 1'b1;
					end
					if (walk_done && !v_s1)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					res_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/periodic_timer_table.sv
// Top level of the periodic timer table: front queue and slot engine.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  command | cmd_valid, cmd_stall | operation slot interval run_now repeat_mode
//          |                      | auto_delete now_ms
//  result  | res_valid, res_stall | fired fired_slot last
//
// Add and remove are executed in the slot engine when popped; a poll holds it while it
// walks the slots, one slot a cycle while the result is not stalled, through a two-stage
// read-modify-write of the slot store, then the closing beat. A two-beat queue sits
// between the front and the engine, so commands are still taken while a poll runs or
// a result waits, until the queue is full. Reset clears slot valid bits and all control;
// the slot store holds no reset. A stalled result freezes the engine.
module periodic_timer_table import ptt_pkg::*; #(
	parameter int NumTimers = NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  operation,
	input  logic [2:0]  slot,
	input  logic [31:0] interval,
	input  logic        run_now,
	input  logic        repeat_mode,
	input  logic        auto_delete,
	input  logic [63:0] now_ms,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        fired,
	output logic [2:0]  fired_slot,
	output logic        last
);

	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	ptt_front #(.NumTimers(NumTimers)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.operation   (operation),
		.slot        (slot),
		.interval    (interval),
		.run_now     (run_now),
		.repeat_mode (repeat_mode),
		.auto_delete (auto_delete),
		.now_ms      (now_ms),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop)
	);

	ptt_back #(.NumTimers(NumTimers)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.fired      (fired),
		.fired_slot (fired_slot),
		.last       (last)
	);

endmodule

FILE: dv/timer_mirror.sv
// Timer table mirror: predicts the result beats of each poll and scores the result channel.
module timer_mirror import ptt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [1:0]  operation,
	input  logic [2:0]  slot,
	input  logic [31:0] interval,
	input  logic        run_now,
	input  logic        repeat_mode,
	input  logic        auto_delete,
	input  logic [63:0] now_ms,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic        fired,
	input  logic [2:0]  fired_slot,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          fire_beats,
	output int          empty_beats
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = NUM_TIMERS_DEF;

	typedef struct packed {
		logic       fire;
		logic [2:0] idx;
		logic       tail;
	} beat_t;

	beat_t       due_q[$];
	logic        tmr_valid  [NT];
	logic [31:0] tmr_period [NT];
	logic [63:0] tmr_expiry [NT];
	logic [3:0]  tmr_flags  [NT];

	task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
		fail_count++;
		$display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// expiry step, all modulo 2^64
	task automatic advance_expiry(input logic [63:0] e, input logic [63:0] p,
			input logic [63:0] t, output logic [63:0] e_next, output logic hit);
		logic [63:0] due;
		due = t + p;
		e_next = e;
		if (due < e_next) e_next = '0;
		if (e_next == '0) e_next = due;
		if (e_next > t) begin
			hit = 1'b0;
		end else begin
			hit = 1'b1;
			e_next = ((t - e_next) > p) ? due : e_next + p;
		end
	endtask

	task automatic run_poll(input logic [63:0] t);
		int          n;
		logic        once;
		logic        hit;
		logic [3:0]  f;
		logic [63:0] e_next;
		n = 0;
		for (int i = 0; i < NT; i++) begin
			if (tmr_valid[i]) begin
				f = tmr_flags[i];
				once = (tmr_expiry[i] == '0) && f[FL_RUN] && !f[FL_CALLED];
				advance_expiry(tmr_expiry[i], {32'b0, tmr_period[i]}, t, e_next, hit);
				tmr_expiry[i] = e_next;
				if (once || hit) begin
					if (f[FL_RPT] || !f[FL_CALLED]) begin
						due_q.push_back('{fire: 1'b1, idx: 3'(i), tail: 1'b0});
						n++;
					end
					f[FL_CALLED] = 1'b1;
					tmr_flags[i] = f;
					if (!f[FL_RPT] && f[FL_ADEL]) tmr_valid[i] = 1'b0;
				end
			end
		end
		if (n == 0) due_q.push_back('{fire: 1'b0, idx: 3'd0, tail: 1'b1});
		else due_q[due_q.size() - 1].tail = 1'b1;
	endtask

	task automatic apply_cmd();
		logic [3:0] f;
		f = '0;
		case (operation)
			OP_ADD: begin
				if (int'(slot) < NT) begin
					f[FL_RUN]  = run_now;
					f[FL_RPT]  = repeat_mode;
					f[FL_ADEL] = auto_delete;
					tmr_period[slot] = interval;
					tmr_expiry[slot] = '0;
					tmr_flags[slot]  = f;
					tmr_valid[slot]  = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (int'(slot) < NT) tmr_valid[slot] = 1'b0;
			end
			OP_POLL: run_poll(now_ms);
			default: ;
		endcase
	endtask

	task automatic check_beat();
		beat_t want;
		if (due_q.size() == 0) begin
			report("unexpected result beat", 8'd0, {3'b0, fired, fired_slot, last});
			return;
		end
		want = due_q.pop_front();
		if (fired !== want.fire) report("fired", 8'(want.fire), 8'(fired));
		if (fired_slot !== want.idx) report("fired_slot", 8'(want.idx), 8'(fired_slot));
		if (last !== want.tail) report("last", 8'(want.tail), 8'(last));
		if (want.fire) fire_beats++;
		else empty_beats++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) tmr_valid[i] = 1'b0;
			due_q.delete();
			pending = 0;
		end else begin
			if (res_valid && !res_stall) check_beat();
			if (cmd_valid && !cmd_stall) apply_cmd();
			pending = due_q.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// Regression top for the periodic timer table: clock, reset, command and result drivers, verdict.
module testbench import ptt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  operation = OP_ADD;
	logic [2:0]  slot = '0;
	logic [31:0] interval = '0;
	logic        run_now = 1'b0;
	logic        repeat_mode = 1'b0;
	logic        auto_delete = 1'b0;
	logic [63:0] now_ms = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        fired;
	logic [2:0]  fired_slot;
	logic        last;

	int fail_count;
	int pending;
	int fire_beats;
	int empty_beats;

	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          rx_hold_req = 1'b0;
	int          n_cmds = 0;
	int          n_polls = 0;
	logic [63:0] tnow = '0;

	periodic_timer_table uut (.*);
	timer_mirror mirror (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("periodic_timer_table regression: fail");
		$finish;
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// starts and returns at a clock edge; returns at the edge the beat is taken
	task automatic send_cmd(input logic [1:0] op, input logic [2:0] s, input logic [31:0] p,
			input logic r, input logic rp, input logic ad, input logic [63:0] t);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid   <= 1'b1;
		operation   <= op;
		slot        <= s;
		interval    <= p;
		run_now     <= r;
		repeat_mode <= rp;
		auto_delete <= ad;
		now_ms      <= t;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		n_cmds++;
		if (op == OP_POLL) n_polls++;
	endtask

	task automatic send_poll(input logic [63:0] t);
		send_cmd(OP_POLL, 3'($urandom_range(0, 7)), $urandom, 1'($urandom), 1'($urandom),
			1'($urandom), t);
	endtask

	task automatic send_random();
		int          pick;
		logic [31:0] p;
		pick = $urandom_range(0, 99);
		p = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
		if (pick < 30) begin
			send_cmd(OP_ADD, 3'($urandom_range(0, 7)), p, 1'($urandom), 1'($urandom),
				1'($urandom), rnd64());
		end else if (pick < 40) begin
			send_cmd(OP_REMOVE, 3'($urandom_range(0, 7)), $urandom, 1'($urandom),
				1'($urandom), 1'($urandom), rnd64());
		end else if (pick < 95) begin
			case ($urandom_range(0, 19))
				0: tnow = rnd64();
				1: tnow = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 30));
				2: tnow = tnow - 64'($urandom_range(0, 50));
				default: tnow = tnow + 64'($urandom_range(0, 25));
			endcase
			send_poll(tnow);
		end else begin
			send_cmd(OP_UNUSED, 3'($urandom_range(0, 7)), $urandom, 1'($urandom),
				1'($urandom), 1'($urandom), rnd64());
		end
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : result_sink
		int gap;
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = rx_idle_on ? $urandom_range(0, 18) : 0;
			end
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: empty table, one-shots, wrap, backwards time, remove, unused op
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd5);
		send_cmd(OP_ADD, 3'd0, 32'd0, 1'b1, 1'b0, 1'b0, rnd64());
		send_cmd(OP_ADD, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, rnd64());
		send_cmd(OP_ADD, 3'd3, 32'd10, 1'b1, 1'b0, 1'b1, rnd64());
		send_cmd(OP_POLL, 3'd7, '1, 1'b1, 1'b1, 1'b1, 64'd0);
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd20);
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd3);
		send_cmd(OP_REMOVE, 3'd5, '0, 1'b0, 1'b0, 1'b0, '0);
		send_cmd(OP_REMOVE, 3'd7, '1, 1'b1, 1'b1, 1'b1, '1);
		send_cmd(OP_UNUSED, 3'd2, '1, 1'b1, 1'b1, 1'b1, '1);
		send_cmd(OP_ADD, 3'd0, 32'd4, 1'b0, 1'b1, 1'b1, '0);
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd100);
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd200);
		for (int s = 0; s < 8; s++) begin
			send_cmd(OP_ADD, 3'(s), 32'd0, 1'b0, 1'b1, 1'b0, rnd64());
		end
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd1000);
		send_cmd(OP_POLL, 3'd0, '0, 1'b0, 1'b0, 1'b0, 64'd1001);
		tnow = 64'd1001;

		repeat (80) send_random();

		// result side held off while polls keep coming, then a full drain
		drain();
		tx_idle_on = 1'b0;
		rx_hold_req = 1'b1;
		repeat (12) begin
			tnow = tnow + 64'($urandom_range(0, 25));
			send_poll(tnow);
		end
		drain();

		rx_idle_on = 1'b0;
		repeat (80) send_random();

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (80) send_random();

		drain();
		repeat (24) @(posedge clk);
		$display("covered %0d commands (%0d polls) over empty, full, wrapped and backward times",
			n_cmds, n_polls);
		$display("checked %0d callback beats and %0d empty-poll beats", fire_beats, empty_beats);
		if (fail_count == 0) begin
			$display("periodic_timer_table regression: pass");
		end else begin
			$display("periodic_timer_table regression: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/ptt_pkg.sv
rtl/ptt_front.sv
rtl/ptt_back.sv
rtl/periodic_timer_table.sv
dv/timer_mirror.sv
dv/testbench.sv
